@@ rtl/pixel_ink_coverage_counter_defines.svh @@
// assertion macros for the ink coverage counter checker
// needs clk and arst_n in the scope of each use
`ifndef PIXEL_INK_COVERAGE_COUNTER_DEFINES_SVH
`define PIXEL_INK_COVERAGE_COUNTER_DEFINES_SVH

// same-cycle implication
`define PIC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pic_pkg.sv @@
// shared types, mode codes and helpers for the ink coverage counter
// no dependencies
package pic_pkg;

	localparam logic [2:0] MODE_CMYK     = 3'd0;
	localparam logic [2:0] MODE_CMY_K    = 3'd1;
	localparam logic [2:0] MODE_CMY      = 3'd2;
	localparam logic [2:0] MODE_GRAY_RGB = 3'd3;
	localparam logic [2:0] MODE_GRAY_K8  = 3'd4;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [7:0] FULL_INK      = 8'd255;
	localparam logic [17:0] GRAY_SQ_MAX  = 18'd24;
	localparam logic [16:0] RECIP3       = 17'd43691;
	localparam logic [7:0] GRAY_R_WEIGHT = 8'd78;
	localparam logic [7:0] GRAY_G_WEIGHT = 8'd151;
	localparam logic [7:0] GRAY_B_WEIGHT = 8'd27;

	typedef struct packed {
		logic [7:0] c;
		logic [7:0] m;
		logic [7:0] y;
		logic [7:0] k;
		logic       last;
		logic [2:0] mode;
	} ink_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CALC,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_ACC,
		B_MUL,
		B_SUM,
		B_FIN,
		B_OUT
	} back_state_t;

	function automatic logic [31:0] sat_add8(logic [31:0] a, logic [7:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {25'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

@@ rtl/pic_fifo.sv @@
// short entry queue between the front classifier and the back accumulator
// depends on pic_pkg
module pic_fifo
	import pic_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  ink_entry_t wr_data,
	input  logic       rd_en,
	output ink_entry_t rd_data,
	output q_status_t  status
);

	ink_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign status.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

@@ rtl/pic_front.sv @@
// front: accepts a pixel, classifies it by mode and forms its ink increments
// depends on pic_pkg; cmyk scaling uses a radix-2 divider, three lanes
module pic_front
	import pic_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] color_mode,
	input  logic       push,
	output logic       full,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       last_pixel,
	output logic       q_wr,
	output ink_entry_t q_data,
	input  q_status_t  q_status
);

	front_state_t state_q, state_d;

	logic [7:0] r_s1, g_s1, b_s1;
	logic       last_s1;
	logic [2:0] mode_s1;

	ink_entry_t entry_q;
	ink_entry_t calc_entry;

	logic [7:0] rem_q [3];
	logic [7:0] lo_q  [3];
	logic [7:0] quo_q [3];
	logic [7:0] w_q;
	logic [2:0] cnt_q;

	logic [7:0]  rem_n [3];
	logic [7:0]  lo_n  [3];
	logic [7:0]  quo_n [3];
	logic [7:0]  inv [3];
	logic [7:0]  diff [3];
	logic [15:0] num [3];
	logic [7:0]  k_min;
	logic [7:0]  dx, dy, dz;
	logic [17:0] sq_sum;
	logic [9:0]  cmy_sum;
	logic [26:0] cmy_div;
	logic        near_gray;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		q_wr    = 1'b0;
		case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push)
					state_d = F_CALC;
			end
			F_CALC: begin
				if (mode_s1 == MODE_CMYK && k_min != FULL_INK)
					state_d = F_DIV;
				else
					state_d = F_PUSH;
			end
			F_DIV: begin
				if (cnt_q == 3'd7)
					state_d = F_PUSH;
			end
			F_PUSH: begin
				q_wr = !q_status.full;
				if (!q_status.full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign q_data = entry_q;

	// inverted channels and mode 0 numerators
	always_comb begin
		inv[0] = ~r_s1;
		inv[1] = ~g_s1;
		inv[2] = ~b_s1;
		k_min  = (inv[0] < inv[1]) ? inv[0] : inv[1];
		k_min  = (inv[2] < k_min) ? inv[2] : k_min;
		for (int i = 0; i < 3; i++) begin
			diff[i] = inv[i] - k_min;
			num[i]  = {diff[i], 8'd0} - {8'd0, diff[i]};
		end
	end

	// near-gray test and mean for mode 1
	always_comb begin
		dx        = (inv[0] > inv[1]) ? inv[0] - inv[1] : inv[1] - inv[0];
		dy        = (inv[0] > inv[2]) ? inv[0] - inv[2] : inv[2] - inv[0];
		dz        = (inv[1] > inv[2]) ? inv[1] - inv[2] : inv[2] - inv[1];
		sq_sum    = {2'd0, {8'd0, dx} * {8'd0, dx}} + {2'd0, {8'd0, dy} * {8'd0, dy}}
			+ {2'd0, {8'd0, dz} * {8'd0, dz}};
		near_gray = (sq_sum <= GRAY_SQ_MAX);
		cmy_sum   = {2'd0, inv[0]} + {2'd0, inv[1]} + {2'd0, inv[2]};
		cmy_div   = {17'd0, cmy_sum} * {10'd0, RECIP3};
	end

	always_comb begin
		calc_entry      = '0;
		calc_entry.last = last_s1;
		calc_entry.mode = mode_s1;
		case (mode_s1)
			MODE_CMYK: begin
				calc_entry.k = k_min;
			end
			MODE_CMY_K: begin
				if (near_gray) begin
					calc_entry.k = cmy_div[24:17];
				end else begin
					calc_entry.c = inv[0];
					calc_entry.m = inv[1];
					calc_entry.y = inv[2];
				end
			end
			MODE_CMY: begin
				calc_entry.c = inv[0];
				calc_entry.m = inv[1];
				calc_entry.y = inv[2];
			end
			MODE_GRAY_RGB: begin
				calc_entry.c = r_s1;
				calc_entry.m = g_s1;
				calc_entry.y = b_s1;
			end
			MODE_GRAY_K8: begin
				calc_entry.k = inv[0];
			end
			default: ;
		endcase
	end

	// one quotient bit per lane per cycle
	always_comb begin
		logic [8:0] t;
		for (int i = 0; i < 3; i++) begin
			t = {rem_q[i], lo_q[i][7]};
			if (t >= {1'b0, w_q}) begin
				rem_n[i] = 8'(t - {1'b0, w_q});
				quo_n[i] = {quo_q[i][6:0], 1'b1};
			end else begin
				rem_n[i] = t[7:0];
				quo_n[i] = {quo_q[i][6:0], 1'b0};
			end
			lo_n[i] = {lo_q[i][6:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			r_s1    <= red;
			g_s1    <= green;
			b_s1    <= blue;
			last_s1 <= last_pixel;
			mode_s1 <= color_mode;
		end
		if (state_q == F_CALC) begin
			entry_q <= calc_entry;
			w_q     <= ~k_min;
			cnt_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= num[i][15:8];
				lo_q[i]  <= num[i][7:0];
				quo_q[i] <= '0;
			end
		end
		if (state_q == F_DIV) begin
			cnt_q <= cnt_q + 1'b1;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_n[i];
				lo_q[i]  <= lo_n[i];
				quo_q[i] <= quo_n[i];
			end
			if (cnt_q == 3'd7) begin
				entry_q.c <= quo_n[0];
				entry_q.m <= quo_n[1];
				entry_q.y <= quo_n[2];
			end
		end
	end

endmodule

@@ rtl/pic_back.sv @@
// back: accumulates ink increments, forms the image totals, holds the result
// depends on pic_pkg
module pic_back
	import pic_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	output logic        q_rd,
	input  ink_entry_t  q_data,
	input  q_status_t   q_status,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] cyan_total,
	output logic [31:0] magenta_total,
	output logic [31:0] yellow_total,
	output logic [31:0] black_total,
	output logic [33:0] all_total,
	output logic        count_overflow
);

	localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
	localparam int FULL_W = CNT_W + 8;
	localparam int EXT_W  = (FULL_W > 33) ? FULL_W : 33;

	back_state_t state_q, state_d;

	logic [31:0]       acc_c_q, acc_m_q, acc_y_q, acc_k_q;
	logic [CNT_W-1:0]  pix_cnt_q;
	logic              ovf_q;
	logic [2:0]        mode_q;

	logic [39:0]       prod_r_s1, prod_g_s1, prod_b_s1;
	logic [FULL_W-1:0] full_s1, full_s2;
	logic [31:0]       gray_s2;
	logic [31:0]       tot_c_q, tot_m_q, tot_y_q, tot_k_q;

	logic              out_valid_q;
	logic [39:0]       gray_sum;
	logic [EXT_W-1:0]  full_e, gray_e, gray_k;
	logic [31:0]       gray_k_sat;
	logic [33:0]       sum_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_ACC;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		q_rd    = 1'b0;
		case (state_q)
			B_ACC: begin
				if (!q_status.empty) begin
					q_rd = 1'b1;
					if (q_data.last)
						state_d = B_MUL;
				end
			end
			B_MUL: state_d = B_SUM;
			B_SUM: state_d = B_FIN;
			B_FIN: state_d = B_OUT;
			B_OUT: begin
				if (!out_valid_q)
					state_d = B_ACC;
			end
			default: state_d = B_ACC;
		endcase
	end

	assign empty    = !out_valid_q;
	assign gray_sum = prod_r_s1 + prod_g_s1 + prod_b_s1;
	assign full_e   = EXT_W'(full_s2);
	assign gray_e   = EXT_W'(gray_s2);
	assign gray_k   = (gray_e > full_e) ? '0 : full_e - gray_e;
	assign gray_k_sat = (gray_k > EXT_W'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : gray_k[31:0];
	assign sum_all  = {2'd0, tot_c_q} + {2'd0, tot_m_q} + {2'd0, tot_y_q} + {2'd0, tot_k_q};

	// accumulators and pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_c_q     <= '0;
			acc_m_q     <= '0;
			acc_y_q     <= '0;
			acc_k_q     <= '0;
			pix_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				if (!pix_cnt_q[CNT_W-1]) begin
					acc_c_q   <= sat_add8(acc_c_q, q_data.c);
					acc_m_q   <= sat_add8(acc_m_q, q_data.m);
					acc_y_q   <= sat_add8(acc_y_q, q_data.y);
					acc_k_q   <= sat_add8(acc_k_q, q_data.k);
					pix_cnt_q <= pix_cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			if (state_q == B_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
				acc_c_q     <= '0;
				acc_m_q     <= '0;
				acc_y_q     <= '0;
				acc_k_q     <= '0;
				pix_cnt_q   <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// result formation
	always_ff @(posedge clk) begin
		if (q_rd && q_data.last)
			mode_q <= q_data.mode;
		if (state_q == B_MUL) begin
			prod_r_s1 <= {8'd0, acc_c_q} * {32'd0, GRAY_R_WEIGHT};
			prod_g_s1 <= {8'd0, acc_m_q} * {32'd0, GRAY_G_WEIGHT};
			prod_b_s1 <= {8'd0, acc_y_q} * {32'd0, GRAY_B_WEIGHT};
			full_s1   <= {pix_cnt_q, 8'd0} - {8'd0, pix_cnt_q};
		end
		if (state_q == B_SUM) begin
			gray_s2 <= gray_sum[39:8];
			full_s2 <= full_s1;
		end
		if (state_q == B_FIN) begin
			case (mode_q)
				MODE_CMYK, MODE_CMY_K: begin
					tot_c_q <= acc_c_q;
					tot_m_q <= acc_m_q;
					tot_y_q <= acc_y_q;
					tot_k_q <= acc_k_q;
				end
				MODE_CMY: begin
					tot_c_q <= acc_c_q;
					tot_m_q <= acc_m_q;
					tot_y_q <= acc_y_q;
					tot_k_q <= '0;
				end
				MODE_GRAY_RGB: begin
					tot_c_q <= '0;
					tot_m_q <= '0;
					tot_y_q <= '0;
					tot_k_q <= gray_k_sat;
				end
				MODE_GRAY_K8: begin
					tot_c_q <= '0;
					tot_m_q <= '0;
					tot_y_q <= '0;
					tot_k_q <= acc_k_q;
				end
				default: begin
					tot_c_q <= '0;
					tot_m_q <= '0;
					tot_y_q <= '0;
					tot_k_q <= '0;
				end
			endcase
		end
		if (state_q == B_OUT && !out_valid_q) begin
			cyan_total     <= tot_c_q;
			magenta_total  <= tot_m_q;
			yellow_total   <= tot_y_q;
			black_total    <= tot_k_q;
			all_total      <= sum_all;
			count_overflow <= ovf_q;
		end
	end

endmodule

@@ rtl/pixel_ink_coverage_counter.sv @@
// Ink coverage counter: one pixel per beat, one result per image on the last pixel.
// The front takes a new pixel only once the last entry is queued; non-black cmyk
// pixels pass the 8-step radix-2 divider. The back takes one entry per cycle while
// accumulating, then runs multiply, sum, finish and output states to the result.
// Reset: async active low, clears mode to cmyk, accumulators, queue and the result valid flag.
// depends on pic_pkg, pic_front, pic_fifo, pic_back
module pixel_ink_coverage_counter
	import pic_pkg::*;
#(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        last_pixel,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] cyan_total,
	output logic [31:0] magenta_total,
	output logic [31:0] yellow_total,
	output logic [31:0] black_total,
	output logic [33:0] all_total,
	output logic        count_overflow
);

	logic [2:0] mode_q;
	logic       q_wr;
	logic       q_rd;
	ink_entry_t q_wr_data;
	ink_entry_t q_rd_data;
	q_status_t  q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_CMYK;
		else if (cfg_valid)
			mode_q <= cfg_data;
	end

	pic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.color_mode (mode_q),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.q_wr       (q_wr),
		.q_data     (q_wr_data),
		.q_status   (q_status)
	);

	pic_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	pic_back #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_rd           (q_rd),
		.q_data         (q_rd_data),
		.q_status       (q_status),
		.empty          (empty),
		.pop            (pop),
		.cyan_total     (cyan_total),
		.magenta_total  (magenta_total),
		.yellow_total   (yellow_total),
		.black_total    (black_total),
		.all_total      (all_total),
		.count_overflow (count_overflow)
	);

endmodule

@@ rtl/pic_checker.sv @@
// port-level checks for the ink coverage counter, bound to the top level
// depends on pixel_ink_coverage_counter_defines.svh
`include "pixel_ink_coverage_counter_defines.svh"

module pic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        last_pixel,
	input logic        empty,
	input logic        pop,
	input logic [31:0] cyan_total,
	input logic [31:0] magenta_total,
	input logic [31:0] yellow_total,
	input logic [31:0] black_total,
	input logic [33:0] all_total,
	input logic        count_overflow
);

	logic [3:0]  pending_q;
	logic        last_beat;
	logic        res_beat;
	logic [33:0] ink_sum;

	assign last_beat = push && !full && last_pixel;
	assign res_beat  = pop && !empty;
	assign ink_sum   = {2'd0, cyan_total} + {2'd0, magenta_total}
		+ {2'd0, yellow_total} + {2'd0, black_total};

	// images whose last pixel went in but whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (last_beat && !res_beat)
			pending_q <= pending_q + 1'b1;
		else if (res_beat && !last_beat)
			pending_q <= pending_q - 1'b1;
	end

	`PIC_ASSERT_IMPLY(a_total_sum, !empty, all_total == ink_sum, "all_total is not the ink sum")
	`PIC_ASSERT_IMPLY(a_result_has_image, !empty, pending_q != 4'd0, "result without a last pixel")
	`PIC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(all_total) && $stable(count_overflow), "result changed while stalled")

endmodule

bind pixel_ink_coverage_counter pic_checker u_pic_checker (.*);

@@ tb/tb_pixel_ink_coverage_counter.sv @@
// testbench for pixel_ink_coverage_counter: directed and random images in all color modes,
// predicted totals checked beat by beat against the result queue
// depends on pic_pkg and the pixel_ink_coverage_counter rtl
module tb_pixel_ink_coverage_counter;
	timeunit 1ns;
	timeprecision 1ps;
	import pic_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_PIXELS = 1150;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [2:0] MODE_RSVD_5 = 3'd5;
	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;
	localparam logic [31:0] INK_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] c;
		logic [31:0] m;
		logic [31:0] y;
		logic [31:0] k;
		logic [33:0] all;
		logic        ovf;
	} ink_totals_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;
	logic        push;
	logic        full;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_pixel;
	logic        empty;
	logic        pop;
	logic [31:0] cyan_total;
	logic [31:0] magenta_total;
	logic [31:0] yellow_total;
	logic [31:0] black_total;
	logic [33:0] all_total;
	logic        count_overflow;

	pixel_ink_coverage_counter #(
		.PIXEL_COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel),
		.empty(empty),
		.pop(pop),
		.cyan_total(cyan_total),
		.magenta_total(magenta_total),
		.yellow_total(yellow_total),
		.black_total(black_total),
		.all_total(all_total),
		.count_overflow(count_overflow)
	);

	// predicted image state
	logic [2:0]  ink_mode = MODE_CMYK;
	logic [31:0] acc_c = '0;
	logic [31:0] acc_m = '0;
	logic [31:0] acc_y = '0;
	logic [31:0] acc_k = '0;
	int          px_count = 0;
	logic        ovf_seen = 1'b0;

	ink_totals_t pending_totals[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          hold_left = 0;
	bit          no_gaps = 0;
	bit          steady_sink = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] sat32(logic [31:0] a, int unsigned b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? INK_MAX : s[31:0];
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [2:0] random_mode();
		int r;
		r = $urandom_range(0, 9);
		return (r < 8) ? 3'(r) : MODE_CMYK;
	endfunction

	function automatic logic [23:0] random_rgb();
		int kind;
		logic [7:0] base;
		logic [7:0] ch [3];
		kind = $urandom_range(0, 9);
		base = 8'($urandom_range(0, 250));
		for (int i = 0; i < 3; i++) begin
			if (kind < 5)
				ch[i] = 8'($urandom_range(0, 255));
			else if (kind < 8)
				ch[i] = base + 8'($urandom_range(0, 5));
			else
				ch[i] = $urandom_range(0, 1) ? FULL_INK : 8'd0;
		end
		return {ch[0], ch[1], ch[2]};
	endfunction

	task automatic account_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic last);
		int c, m, y, k, w, dx, dy, dz, sq;
		longint unsigned full_ink, gray, kt;
		ink_totals_t t;
		c = 255 - int'(r);
		m = 255 - int'(g);
		y = 255 - int'(b);
		if (px_count < (1 << COUNT_BITS)) begin
			case (ink_mode)
				MODE_CMYK: begin
					k = (c < m) ? c : m;
					if (y < k)
						k = y;
					if (k != 255) begin
						w = 255 - k;
						acc_c = sat32(acc_c, 255 * (c - k) / w);
						acc_m = sat32(acc_m, 255 * (m - k) / w);
						acc_y = sat32(acc_y, 255 * (y - k) / w);
					end
					acc_k = sat32(acc_k, k);
				end
				MODE_CMY_K: begin
					dx = (c > m) ? c - m : m - c;
					dy = (c > y) ? c - y : y - c;
					dz = (m > y) ? m - y : y - m;
					sq = (dx * dx + dy * dy + dz * dz + 2) / 3;
					if (sq <= 8) begin
						acc_k = sat32(acc_k, (c + m + y) / 3);
					end else begin
						acc_c = sat32(acc_c, c);
						acc_m = sat32(acc_m, m);
						acc_y = sat32(acc_y, y);
					end
				end
				MODE_CMY: begin
					acc_c = sat32(acc_c, c);
					acc_m = sat32(acc_m, m);
					acc_y = sat32(acc_y, y);
				end
				MODE_GRAY_RGB: begin
					acc_c = sat32(acc_c, r);
					acc_m = sat32(acc_m, g);
					acc_y = sat32(acc_y, b);
				end
				MODE_GRAY_K8:
					acc_k = sat32(acc_k, c);
				default: ;
			endcase
			px_count++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (last) begin
			t = '0;
			case (ink_mode)
				MODE_GRAY_RGB: begin
					full_ink = 255 * longint'(px_count);
					gray = (78 * longint'(acc_c) + 151 * longint'(acc_m)
						+ 27 * longint'(acc_y)) / 256;
					kt = (gray > full_ink) ? 0 : full_ink - gray;
					t.k = (kt > INK_MAX) ? INK_MAX : kt[31:0];
				end
				MODE_GRAY_K8:
					t.k = acc_k;
				MODE_CMY: begin
					t.c = acc_c;
					t.m = acc_m;
					t.y = acc_y;
				end
				MODE_CMYK, MODE_CMY_K: begin
					t.c = acc_c;
					t.m = acc_m;
					t.y = acc_y;
					t.k = acc_k;
				end
				default: ;
			endcase
			t.all = {2'b0, t.c} + {2'b0, t.m} + {2'b0, t.y} + {2'b0, t.k};
			t.ovf = ovf_seen;
			pending_totals.push_back(t);
			acc_c = '0;
			acc_m = '0;
			acc_y = '0;
			acc_k = '0;
			px_count = 0;
			ovf_seen = 1'b0;
		end
	endtask

	// entered and left at a falling edge
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic last);
		int gap;
		gap = no_gaps ? 0 : pick_stall();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		last_pixel <= last;
		do @(posedge clk); while (full);
		account_pixel(r, g, b, last);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (pending_totals.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [2:0] mode);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		ink_mode = mode;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_cmyk_after_reset();
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd10, 8'd200, 8'd90, 1'b1);
	endtask

	task automatic test_near_gray_black();
		write_mode(MODE_CMY_K);
		send_pixel(8'd200, 8'd196, 8'd198, 1'b0);
		send_pixel(8'd200, 8'd196, 8'd199, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd128, 1'b1);
	endtask

	task automatic test_cmy();
		write_mode(MODE_CMY);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd128, 8'd1, 1'b1);
	endtask

	task automatic test_gray_rgb();
		write_mode(MODE_GRAY_RGB);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd128, 1'b1);
	endtask

	task automatic test_gray_k8();
		write_mode(MODE_GRAY_K8);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
	endtask

	task automatic test_reserved_modes();
		write_mode(MODE_RSVD_5);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		write_mode(MODE_RSVD_6);
		send_pixel(8'd127, 8'd64, 8'd200, 1'b1);
		write_mode(MODE_RSVD_7);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
	endtask

	task automatic test_mode_switch_in_image();
		write_mode(MODE_CMY);
		send_pixel(8'd30, 8'd60, 8'd90, 1'b0);
		write_mode(MODE_GRAY_RGB);
		send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
		write_mode(MODE_CMYK);
		send_pixel(8'd5, 8'd6, 8'd7, 1'b1);
		write_mode(MODE_CMY);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		write_mode(MODE_GRAY_RGB);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
	endtask

	task automatic test_result_backpressure();
		logic [23:0] px;
		write_mode(MODE_CMY);
		hold_left = 400;
		for (int i = 0; i < 16; i++) begin
			px = random_rgb();
			send_pixel(px[23:16], px[15:8], px[7:0], 1'b1);
		end
	endtask

	task automatic test_random_images();
		int sent;
		int len;
		logic [23:0] px;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 3) == 0)
				write_mode(random_mode());
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			no_gaps = ($urandom_range(0, 6) == 0);
			steady_sink = ($urandom_range(0, 6) == 0);
			for (int i = 0; i < len; i++) begin
				px = random_rgb();
				send_pixel(px[23:16], px[15:8], px[7:0], i == len - 1);
				sent++;
				if (i < len - 1 && $urandom_range(0, 29) == 0)
					write_mode(random_mode());
			end
		end
		no_gaps = 0;
		steady_sink = 0;
	endtask

	// result side
	initial begin
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else if (steady_sink) begin
				pop <= 1'b1;
			end else begin
				stall_left = pick_stall();
				if (stall_left > 0) begin
					pop <= 1'b0;
					stall_left--;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		ink_totals_t t;
		if (arst_n && pop && !empty) begin
			if (pending_totals.size() == 0) begin
				$error("result beat with no totals expected");
				mismatches++;
			end else begin
				t = pending_totals.pop_front();
				if (cyan_total !== t.c) begin
					$error("cyan_total expected %0d actual %0d", t.c, cyan_total);
					mismatches++;
				end
				if (magenta_total !== t.m) begin
					$error("magenta_total expected %0d actual %0d", t.m, magenta_total);
					mismatches++;
				end
				if (yellow_total !== t.y) begin
					$error("yellow_total expected %0d actual %0d", t.y, yellow_total);
					mismatches++;
				end
				if (black_total !== t.k) begin
					$error("black_total expected %0d actual %0d", t.k, black_total);
					mismatches++;
				end
				if (all_total !== t.all) begin
					$error("all_total expected %0d actual %0d", t.all, all_total);
					mismatches++;
				end
				if (count_overflow !== t.ovf) begin
					$error("count_overflow expected %0d actual %0d", t.ovf, count_overflow);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL pixel_ink_coverage_counter");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = MODE_CMYK;
		push = 1'b0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		last_pixel = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_cmyk_after_reset();
		test_near_gray_black();
		test_cmy();
		test_gray_rgb();
		test_gray_k8();
		test_reserved_modes();
		test_mode_switch_in_image();
		test_result_backpressure();
		test_random_images();

		push <= 1'b0;
		while (pending_totals.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_totals.size() == 0)
			$display("PASS pixel_ink_coverage_counter");
		else
			$display("FAIL pixel_ink_coverage_counter");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pic_pkg.sv
rtl/pic_fifo.sv
rtl/pic_front.sv
rtl/pic_back.sv
rtl/pixel_ink_coverage_counter.sv
rtl/pic_checker.sv
tb/tb_pixel_ink_coverage_counter.sv
